[sv/etk_pkg.sv]
// Shared types, token codes and character helpers for the expression tokenizer.
// No dependencies; used by etk_lex, etk_fifo and expression_tokenizer_core.
package etk_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 64;
  localparam int FIFO_DEPTH        = 4;

  localparam int KIND_W = 5;
  localparam int OFF_W  = 16;
  localparam int LEN_W  = 7;

  // Token kind codes
  localparam logic [KIND_W-1:0] KIND_INTLIT = 5'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_TRUE   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_FALSE  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_INT    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd6;
  localparam logic [KIND_W-1:0] KIND_STAR   = 5'd7;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_GT     = 5'd9;
  localparam logic [KIND_W-1:0] KIND_LT     = 5'd11;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd13;
  localparam logic [KIND_W-1:0] KIND_AMP    = 5'd15;
  localparam logic [KIND_W-1:0] KIND_PIPE   = 5'd17;
  localparam logic [KIND_W-1:0] KIND_BANG   = 5'd19;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd21;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd22;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd23;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd24;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd25;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd26;
  localparam logic [KIND_W-1:0] KIND_EOL    = 5'd27;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd28;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Keyword candidate bits
  localparam int CAND_TRUE  = 0;
  localparam int CAND_FALSE = 1;
  localparam int CAND_INT   = 2;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_INTL  = 4'd1,
    M_IDENT = 4'd2,
    M_GT    = 4'd3,
    M_LT    = 4'd4,
    M_EQ    = 4'd5,
    M_AMP   = 4'd6,
    M_PIPE  = 4'd7,
    M_BANG  = 4'd8
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [OFF_W-1:0]  tok_start;
    logic [LEN_W-1:0]  tok_len;
    logic              ovf;
    logic [2:0]        cand;
    logic [OFF_W-1:0]  offset;
  } lex_state_t;

  typedef struct packed {
    logic              last;
    logic              too_long;
    logic [LEN_W-1:0]  length;
    logic [OFF_W-1:0]  start;
    logic [KIND_W-1:0] kind;
  } token_t;

  // Up to two tokens produced by one character, a first
  typedef struct packed {
    logic [1:0] n;
    token_t     a;
    token_t     b;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic kw_true_ok(input logic [LEN_W-1:0] p, input logic [7:0] c);
    case (p)
      7'd0:    return c == CH_T;
      7'd1:    return c == CH_R;
      7'd2:    return c == CH_U;
      7'd3:    return c == CH_E;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic kw_false_ok(input logic [LEN_W-1:0] p, input logic [7:0] c);
    case (p)
      7'd0:    return c == CH_F;
      7'd1:    return c == CH_A;
      7'd2:    return c == CH_L;
      7'd3:    return c == CH_S;
      7'd4:    return c == CH_E;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic kw_int_ok(input logic [LEN_W-1:0] p, input logic [7:0] c);
    case (p)
      7'd0:    return c == CH_I;
      7'd1:    return c == CH_N;
      7'd2:    return c == CH_T;
      default: return 1'b0;
    endcase
  endfunction

endpackage

[sv/etk_lex.sv]
// One-character scan step of the tokenizer: next scanner state and up to two tokens.
// Depends on etk_pkg.
module etk_lex #(
  parameter int MAX_TOKEN_LEN = etk_pkg::MAX_TOKEN_LEN_DEF
) (
  input  etk_pkg::lex_state_t st_i,
  input  logic [7:0]          char_i,
  output etk_pkg::lex_state_t st_o,
  output etk_pkg::push_t      push_o
);

  localparam logic [etk_pkg::LEN_W-1:0] MAX_LEN = etk_pkg::LEN_W'(MAX_TOKEN_LEN);

  always_comb begin
    etk_pkg::lex_state_t       nxt;
    etk_pkg::token_t           pend;
    etk_pkg::token_t           self_tok;
    logic                      has_pend;
    logic                      has_self;
    logic                      done;
    logic                      cont;
    logic [7:0]                second;
    logic [etk_pkg::KIND_W-1:0] single;
    logic [etk_pkg::KIND_W-1:0] wkind;
    logic [2:0]                cand;

    nxt        = st_i;
    nxt.offset = st_i.offset + 16'd1;
    pend       = '0;
    self_tok   = '0;
    has_pend   = 1'b0;
    has_self   = 1'b0;
    done       = 1'b0;
    cont       = 1'b0;
    second     = etk_pkg::CH_EQ;
    single     = etk_pkg::KIND_BANG;
    cand       = 3'b000;

    // Word kind of the pending identifier
    wkind = etk_pkg::KIND_IDENT;
    if (!st_i.ovf) begin
      if (st_i.tok_len == 7'd4 && st_i.cand[etk_pkg::CAND_TRUE]) begin
        wkind = etk_pkg::KIND_TRUE;
      end else if (st_i.tok_len == 7'd5 && st_i.cand[etk_pkg::CAND_FALSE]) begin
        wkind = etk_pkg::KIND_FALSE;
      end else if (st_i.tok_len == 7'd3 && st_i.cand[etk_pkg::CAND_INT]) begin
        wkind = etk_pkg::KIND_INT;
      end
    end

    if (st_i.mode == etk_pkg::M_INTL || st_i.mode == etk_pkg::M_IDENT) begin
      cont = (st_i.mode == etk_pkg::M_INTL  && etk_pkg::is_digit(char_i)) ||
             (st_i.mode == etk_pkg::M_IDENT && etk_pkg::is_word(char_i));
      if (cont) begin
        done = 1'b1;
        if (st_i.mode == etk_pkg::M_IDENT) begin
          cand[etk_pkg::CAND_TRUE]  = st_i.cand[etk_pkg::CAND_TRUE] &&
                                      etk_pkg::kw_true_ok(st_i.tok_len, char_i);
          cand[etk_pkg::CAND_FALSE] = st_i.cand[etk_pkg::CAND_FALSE] &&
                                      etk_pkg::kw_false_ok(st_i.tok_len, char_i);
          cand[etk_pkg::CAND_INT]   = st_i.cand[etk_pkg::CAND_INT] &&
                                      etk_pkg::kw_int_ok(st_i.tok_len, char_i);
          nxt.cand = cand;
        end
        if (st_i.tok_len < MAX_LEN) begin
          nxt.tok_len = st_i.tok_len + 7'd1;
        end else begin
          nxt.ovf  = 1'b1;
          nxt.cand = 3'b000;
        end
      end else begin
        has_pend      = 1'b1;
        pend.kind     = (st_i.mode == etk_pkg::M_INTL) ? etk_pkg::KIND_INTLIT : wkind;
        pend.start    = st_i.tok_start;
        pend.length   = st_i.tok_len;
        pend.too_long = st_i.ovf;
      end
    end else if (st_i.mode != etk_pkg::M_IDLE) begin
      unique case (st_i.mode)
        etk_pkg::M_GT:   begin second = etk_pkg::CH_EQ;   single = etk_pkg::KIND_GT;     end
        etk_pkg::M_LT:   begin second = etk_pkg::CH_EQ;   single = etk_pkg::KIND_LT;     end
        etk_pkg::M_EQ:   begin second = etk_pkg::CH_EQ;   single = etk_pkg::KIND_ASSIGN; end
        etk_pkg::M_AMP:  begin second = etk_pkg::CH_AMP;  single = etk_pkg::KIND_AMP;    end
        etk_pkg::M_PIPE: begin second = etk_pkg::CH_PIPE; single = etk_pkg::KIND_PIPE;   end
        default:         begin second = etk_pkg::CH_EQ;   single = etk_pkg::KIND_BANG;   end
      endcase
      has_pend   = 1'b1;
      pend.start = st_i.tok_start;
      nxt.mode   = etk_pkg::M_IDLE;
      if (char_i == second) begin
        // Two-character operator swallows this character
        done        = 1'b1;
        pend.kind   = single + 5'd1;
        pend.length = 7'd2;
      end else begin
        pend.kind   = single;
        pend.length = 7'd1;
      end
    end

    if (!done) begin
      nxt.mode = etk_pkg::M_IDLE;
      if (etk_pkg::is_digit(char_i) || etk_pkg::is_word(char_i)) begin
        nxt.mode      = etk_pkg::is_digit(char_i) ? etk_pkg::M_INTL : etk_pkg::M_IDENT;
        nxt.tok_start = st_i.offset;
        nxt.tok_len   = 7'd1;
        nxt.ovf       = 1'b0;
        nxt.cand      = {char_i == etk_pkg::CH_I, char_i == etk_pkg::CH_F,
                         char_i == etk_pkg::CH_T};
      end else begin
        has_self        = 1'b1;
        self_tok.start  = st_i.offset;
        self_tok.length = 7'd1;
        self_tok.kind   = etk_pkg::KIND_ERROR;
        case (char_i)
          etk_pkg::CH_GT:     begin nxt.mode = etk_pkg::M_GT;   has_self = 1'b0; end
          etk_pkg::CH_LT:     begin nxt.mode = etk_pkg::M_LT;   has_self = 1'b0; end
          etk_pkg::CH_EQ:     begin nxt.mode = etk_pkg::M_EQ;   has_self = 1'b0; end
          etk_pkg::CH_AMP:    begin nxt.mode = etk_pkg::M_AMP;  has_self = 1'b0; end
          etk_pkg::CH_PIPE:   begin nxt.mode = etk_pkg::M_PIPE; has_self = 1'b0; end
          etk_pkg::CH_BANG:   begin nxt.mode = etk_pkg::M_BANG; has_self = 1'b0; end
          etk_pkg::CH_PLUS:   self_tok.kind = etk_pkg::KIND_PLUS;
          etk_pkg::CH_MINUS:  self_tok.kind = etk_pkg::KIND_MINUS;
          etk_pkg::CH_STAR:   self_tok.kind = etk_pkg::KIND_STAR;
          etk_pkg::CH_SLASH:  self_tok.kind = etk_pkg::KIND_SLASH;
          etk_pkg::CH_LPAREN: self_tok.kind = etk_pkg::KIND_LPAREN;
          etk_pkg::CH_RPAREN: self_tok.kind = etk_pkg::KIND_RPAREN;
          etk_pkg::CH_LBRACE: self_tok.kind = etk_pkg::KIND_LBRACE;
          etk_pkg::CH_RBRACE: self_tok.kind = etk_pkg::KIND_RBRACE;
          etk_pkg::CH_COMMA:  self_tok.kind = etk_pkg::KIND_COMMA;
          etk_pkg::CH_SEMI:   self_tok.kind = etk_pkg::KIND_SEMI;
          etk_pkg::CH_SPACE:  has_self = 1'b0;
          etk_pkg::CH_NL: begin
            self_tok.kind = etk_pkg::KIND_EOL;
            nxt.offset    = '0;
          end
          default: self_tok.kind = etk_pkg::KIND_ERROR;
        endcase
        if (nxt.mode != etk_pkg::M_IDLE) begin
          nxt.tok_start = st_i.offset;
        end
      end
    end

    // Order: pending token first, flag the final one
    push_o = '0;
    if (has_pend && has_self) begin
      push_o.n      = 2'd2;
      push_o.a      = pend;
      push_o.b      = self_tok;
      push_o.b.last = 1'b1;
    end else if (has_pend) begin
      push_o.n      = 2'd1;
      push_o.a      = pend;
      push_o.a.last = 1'b1;
    end else if (has_self) begin
      push_o.n      = 2'd1;
      push_o.a      = self_tok;
      push_o.a.last = 1'b1;
    end
    st_o = nxt;
  end

endmodule

[sv/etk_fifo.sv]
// Small token queue: two writes and one read per cycle, decouples the two channels.
// Depends on etk_pkg.
module etk_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_en_i,
  input  etk_pkg::push_t  push_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output etk_pkg::token_t out_tok_o
);

  localparam int DEPTH = etk_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  etk_pkg::token_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;
  logic [1:0]      n_push;
  logic            pop;

  assign n_push      = push_en_i ? push_i.n : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_r != '0);
  assign out_tok_o   = mem_r[rd_ptr_r];
  // Room for the worst case of two tokens
  assign space_o     = (count_r <= (AW+1)'(DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + AW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign count_nxt  = count_r + (AW+1)'(n_push) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push_i.a;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + AW'(1)] <= push_i.b;
    end
  end

endmodule

[sv/expression_tokenizer_core.sv]
// Top level of the expression tokenizer: scanner state, scan step and token queue.
// Depends on etk_pkg, etk_lex and etk_fifo.
//
//   channel | dir | payload                                         | marker
//   in_     | in  | tdata[7:0] character byte                       | -
//   out_    | out | tdata: kind, start offset, length, too_long     | tlast = final token
//
// One character is taken per cycle. Each accepted beat updates the scanner
// state in the same cycle and queues zero, one or two tokens in a four-entry
// token queue; tokens leave one per cycle while out_tready is high. in_tready
// drops only while the queue holds fewer than two free entries, so input
// stalls only when the output side is slower than the token rate. Reset (rst_n low,
// synchronous) clears the scanner to idle at offset zero and empties the queue.
module expression_tokenizer_core #(
  parameter int MAX_TOKEN_LEN = etk_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [4:0] kind, [20:5] start_offset, [27:21] length,
                                  // [28] too_long, [31:29] zero
  output logic        out_tlast
);

  etk_pkg::lex_state_t st_r, st_nxt, st_step;
  etk_pkg::push_t      push;
  etk_pkg::token_t     out_tok;
  logic                in_beat;

  assign in_beat = in_tvalid && in_tready;

  // Scan step: pure logic from the scanner registers and the incoming byte
  etk_lex #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_lex (
    .st_i   (st_r),
    .char_i (in_tdata),
    .st_o   (st_step),
    .push_o (push)
  );

  // Advance the scanner only on an accepted beat; hold otherwise
  assign st_nxt = in_beat ? st_step : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode      <= etk_pkg::M_IDLE;
      st_r.tok_start <= '0;
      st_r.tok_len   <= '0;
      st_r.ovf       <= 1'b0;
      st_r.cand      <= 3'b111;
      st_r.offset    <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Queue tokens; the result register side drives the output channel
  etk_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_en_i   (in_beat),
    .push_i      (push),
    .space_o     (in_tready),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_tok_o   (out_tok)
  );

  assign out_tdata = {3'b000, out_tok.too_long, out_tok.length, out_tok.start, out_tok.kind};
  assign out_tlast = out_tok.last;

  // A beat that yields tokens makes the output valid on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && push.n != 2'd0) |=> out_tvalid)
    else $error("queued token not visible");

  // Two tokens from one byte only when a token was pending
  a_two_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && push.n == 2'd2) |-> (st_r.mode != etk_pkg::M_IDLE))
    else $error("two tokens without a pending token");

  // Number and word runs always have a length within bounds
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == etk_pkg::M_INTL || st_r.mode == etk_pkg::M_IDENT) |->
    (st_r.tok_len != '0 && st_r.tok_len <= etk_pkg::LEN_W'(MAX_TOKEN_LEN)))
    else $error("run length out of range");

  // Overflow is flagged only at the saturated length
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ovf |-> (st_r.tok_len == etk_pkg::LEN_W'(MAX_TOKEN_LEN)))
    else $error("overflow without saturated length");

endmodule

[bench/etk_checker.sv]
`timescale 1ns / 1ps
// Token checker for the expression tokenizer: predicts tokens from accepted character beats
// and compares them with the output stream. Depends on etk_pkg for token and mode types.
module etk_checker #(
  parameter int MAX_LEN = etk_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  output int          mismatches,
  output int          tokens_waiting,
  output int          chars_taken,
  output int          tokens_seen,
  output int          overlong_seen
);

  etk_pkg::mode_t                 scan_state;
  logic [etk_pkg::OFF_W-1:0]      word_start;
  logic [etk_pkg::LEN_W-1:0]      word_len;
  logic                           word_ovf;
  logic [2:0]                     kw_alive;
  logic [etk_pkg::OFF_W-1:0]      col_offset;

  etk_pkg::token_t   tokens_due[$];
  etk_pkg::token_t   step_tokens[2];
  int                step_n;
  etk_pkg::token_t   want;
  int                errs = 0;
  int                n_chars = 0;
  int                n_tokens = 0;
  int                n_overlong = 0;

  function automatic logic char_is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic char_is_word(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == etk_pkg::CH_UNDER);
  endfunction

  function automatic logic kw_letter_ok(input int which, input int pos, input logic [7:0] c);
    string spelled;
    case (which)
      etk_pkg::CAND_TRUE:  spelled = "true";
      etk_pkg::CAND_FALSE: spelled = "false";
      default:             spelled = "int";
    endcase
    return (pos < spelled.len()) && (spelled[pos] == c);
  endfunction

  task automatic add_token(input logic [etk_pkg::KIND_W-1:0] kind,
                           input logic [etk_pkg::OFF_W-1:0] start,
                           input logic [etk_pkg::LEN_W-1:0] len, input logic ovf);
    step_tokens[step_n] = '{last: 1'b0, too_long: ovf, length: len, start: start, kind: kind};
    step_n++;
  endtask

  // One character through the scanner; fills step_tokens in emission order
  task automatic lex_char(input logic [7:0] c);
    logic [etk_pkg::OFF_W-1:0]  here;
    logic [7:0]                 pair_ch;
    logic [etk_pkg::KIND_W-1:0] lone_kind;
    logic [etk_pkg::KIND_W-1:0] word_kind;
    logic [2:0]                 alive;
    here = col_offset;
    col_offset = here + 16'd1;
    if (scan_state == etk_pkg::M_INTL || scan_state == etk_pkg::M_IDENT) begin
      if ((scan_state == etk_pkg::M_INTL) ? char_is_digit(c) : char_is_word(c)) begin
        if (scan_state == etk_pkg::M_IDENT) begin
          alive = 3'b000;
          for (int k = 0; k < 3; k++) begin
            alive[k] = kw_alive[k] && kw_letter_ok(k, int'(word_len), c);
          end
          kw_alive = alive;
        end
        if (word_len < MAX_LEN) begin
          word_len = word_len + 7'd1;
        end else begin
          word_ovf = 1'b1;
          kw_alive = 3'b000;
        end
        return;
      end
      word_kind = etk_pkg::KIND_INTLIT;
      if (scan_state == etk_pkg::M_IDENT) begin
        word_kind = etk_pkg::KIND_IDENT;
        if (!word_ovf) begin
          if (word_len == 4 && kw_alive[etk_pkg::CAND_TRUE]) word_kind = etk_pkg::KIND_TRUE;
          else if (word_len == 5 && kw_alive[etk_pkg::CAND_FALSE]) begin
            word_kind = etk_pkg::KIND_FALSE;
          end else if (word_len == 3 && kw_alive[etk_pkg::CAND_INT]) begin
            word_kind = etk_pkg::KIND_INT;
          end
        end
      end
      add_token(word_kind, word_start, word_len, word_ovf);
    end else if (scan_state != etk_pkg::M_IDLE) begin
      case (scan_state)
        etk_pkg::M_GT: begin
          pair_ch = etk_pkg::CH_EQ;   lone_kind = etk_pkg::KIND_GT;
        end
        etk_pkg::M_LT: begin
          pair_ch = etk_pkg::CH_EQ;   lone_kind = etk_pkg::KIND_LT;
        end
        etk_pkg::M_EQ: begin
          pair_ch = etk_pkg::CH_EQ;   lone_kind = etk_pkg::KIND_ASSIGN;
        end
        etk_pkg::M_AMP: begin
          pair_ch = etk_pkg::CH_AMP;  lone_kind = etk_pkg::KIND_AMP;
        end
        etk_pkg::M_PIPE: begin
          pair_ch = etk_pkg::CH_PIPE; lone_kind = etk_pkg::KIND_PIPE;
        end
        default: begin
          pair_ch = etk_pkg::CH_EQ;   lone_kind = etk_pkg::KIND_BANG;
        end
      endcase
      scan_state = etk_pkg::M_IDLE;
      if (c == pair_ch) begin
        add_token(lone_kind + 5'd1, word_start, 7'd2, 1'b0);
        return;
      end
      add_token(lone_kind, word_start, 7'd1, 1'b0);
    end
    scan_state = etk_pkg::M_IDLE;

    if (char_is_digit(c) || char_is_word(c)) begin
      scan_state = char_is_digit(c) ? etk_pkg::M_INTL : etk_pkg::M_IDENT;
      word_start = here;
      word_len   = 7'd1;
      word_ovf   = 1'b0;
      kw_alive   = 3'b000;
      kw_alive[etk_pkg::CAND_TRUE]  = (c == etk_pkg::CH_T);
      kw_alive[etk_pkg::CAND_FALSE] = (c == etk_pkg::CH_F);
      kw_alive[etk_pkg::CAND_INT]   = (c == etk_pkg::CH_I);
    end else begin
      case (c)
        etk_pkg::CH_GT:     scan_state = etk_pkg::M_GT;
        etk_pkg::CH_LT:     scan_state = etk_pkg::M_LT;
        etk_pkg::CH_EQ:     scan_state = etk_pkg::M_EQ;
        etk_pkg::CH_AMP:    scan_state = etk_pkg::M_AMP;
        etk_pkg::CH_PIPE:   scan_state = etk_pkg::M_PIPE;
        etk_pkg::CH_BANG:   scan_state = etk_pkg::M_BANG;
        etk_pkg::CH_PLUS:   add_token(etk_pkg::KIND_PLUS, here, 7'd1, 1'b0);
        etk_pkg::CH_MINUS:  add_token(etk_pkg::KIND_MINUS, here, 7'd1, 1'b0);
        etk_pkg::CH_STAR:   add_token(etk_pkg::KIND_STAR, here, 7'd1, 1'b0);
        etk_pkg::CH_SLASH:  add_token(etk_pkg::KIND_SLASH, here, 7'd1, 1'b0);
        etk_pkg::CH_LPAREN: add_token(etk_pkg::KIND_LPAREN, here, 7'd1, 1'b0);
        etk_pkg::CH_RPAREN: add_token(etk_pkg::KIND_RPAREN, here, 7'd1, 1'b0);
        etk_pkg::CH_LBRACE: add_token(etk_pkg::KIND_LBRACE, here, 7'd1, 1'b0);
        etk_pkg::CH_RBRACE: add_token(etk_pkg::KIND_RBRACE, here, 7'd1, 1'b0);
        etk_pkg::CH_COMMA:  add_token(etk_pkg::KIND_COMMA, here, 7'd1, 1'b0);
        etk_pkg::CH_SEMI:   add_token(etk_pkg::KIND_SEMI, here, 7'd1, 1'b0);
        etk_pkg::CH_SPACE:  ;
        etk_pkg::CH_NL: begin
          add_token(etk_pkg::KIND_EOL, here, 7'd1, 1'b0);
          col_offset = '0;
        end
        default:            add_token(etk_pkg::KIND_ERROR, here, 7'd1, 1'b0);
      endcase
      if (scan_state != etk_pkg::M_IDLE) word_start = here;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (actual !== expected) begin
      $display("%0t: token %0d %s mismatch: expected %0d, actual %0d",
               $time, n_tokens, what, expected, actual);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_state = etk_pkg::M_IDLE;
      word_start = '0;
      word_len   = '0;
      word_ovf   = 1'b0;
      kw_alive   = 3'b111;
      col_offset = '0;
      tokens_due.delete();
    end else begin
      // Predict first, so a same-edge token would already be queued
      if (in_tvalid && in_tready) begin
        n_chars++;
        step_n = 0;
        lex_char(in_tdata);
        if (step_n > 0) step_tokens[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) tokens_due.push_back(step_tokens[i]);
      end
      if (out_tvalid && out_tready) begin
        n_tokens++;
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected token tdata=%h tlast=%b, expected none",
                   $time, out_tdata, out_tlast);
          errs++;
        end else begin
          want = tokens_due.pop_front();
          if (want.too_long) n_overlong++;
          check_field("kind", 32'(want.kind), 32'(out_tdata[4:0]));
          check_field("start_offset", 32'(want.start), 32'(out_tdata[20:5]));
          check_field("length", 32'(want.length), 32'(out_tdata[27:21]));
          check_field("too_long", 32'(want.too_long), 32'(out_tdata[28]));
          check_field("tlast", 32'(want.last), 32'(out_tlast));
          check_field("pad", 32'd0, 32'(out_tdata[31:29]));
        end
      end
    end
    mismatches     <= errs;
    tokens_waiting <= tokens_due.size();
    chars_taken    <= n_chars;
    tokens_seen    <= n_tokens;
    overlong_seen  <= n_overlong;
  end

endmodule

[bench/tb_expression_tokenizer_core.sv]
`timescale 1ns / 1ps
// Testbench top for expression_tokenizer_core: drives character beats in idling phases,
// stalls the token side and gives the verdict. Depends on etk_pkg and etk_checker.
module tb_expression_tokenizer_core;

  localparam int TOKEN_CAP   = etk_pkg::MAX_TOKEN_LEN_DEF;
  // No correct run goes quiet for anywhere near this long, even at 76 % idle
  localparam int QUIET_LIMIT = 2000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  int mismatches;
  int tokens_waiting;
  int chars_taken;
  int tokens_seen;
  int overlong_seen;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  // Character text waiting to be driven, oldest first
  logic [7:0] text_q[$];

  string op_spell [0:21] = '{">=", "<=", "==", "!=", "&&", "||", ">", "<", "=", "!", "&",
                             "|", "+", "-", "*", "/", "(", ")", "{", "}", ",", ";"};
  string kw_spell [0:8]  = '{"true", "false", "int", "tru", "fals", "in", "intx", "true_",
                             "False"};

  expression_tokenizer_core #(
    .MAX_TOKEN_LEN(TOKEN_CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  etk_checker #(
    .MAX_LEN(TOKEN_CAP)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .tokens_waiting (tokens_waiting),
    .chars_taken    (chars_taken),
    .tokens_seen    (tokens_seen),
    .overlong_seen  (overlong_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Token side: stall at random, one decision per falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles, %0d tokens still due",
               $time, quiet_cycles, tokens_waiting);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one character beat; enter and leave on a falling edge
  task automatic put_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_text();
    while (text_q.size() > 0) put_char(text_q.pop_front());
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + (r - 26));
    return etk_pkg::CH_UNDER;
  endfunction

  // Build random source text from lexical pieces: mostly well-formed words, numbers,
  // operators and separators, with stray bytes mixed in. Pieces abut freely, so words
  // run into numbers and operators pair up across piece boundaries.
  task automatic append_pieces(input int target);
    int pick;
    int len;
    while (text_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        // Now and then a word around the length cap
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(TOKEN_CAP - 2, TOKEN_CAP + 6)
                                           : $urandom_range(1, 7);
        for (int i = 0; i < len; i++) text_q.push_back(word_letter());
      end else if (pick < 32) begin
        queue_text(kw_spell[$urandom_range(0, 8)]);
      end else if (pick < 45) begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(TOKEN_CAP - 2, TOKEN_CAP + 6)
                                           : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) text_q.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 66) begin
        queue_text(op_spell[$urandom_range(0, 21)]);
      end else if (pick < 82) begin
        text_q.push_back(etk_pkg::CH_SPACE);
      end else if (pick < 89) begin
        text_q.push_back(etk_pkg::CH_NL);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes and control bytes as errors, a keyword, every
    // two-character operator, a newline and a number ended by a space
    text_q = '{8'h00, 8'hFF, 8'h09, 8'h0D};
    queue_text("int >=<=!=&&||==");
    text_q.push_back(etk_pkg::CH_NL);
    queue_text("9 ");
    drain_text();

    // Random text through the idling phases: none, sender, receiver, both
    append_pieces(72);
    drain_text();

    send_idle_pct = 76;
    append_pieces(72);
    drain_text();

    send_idle_pct  = 0;
    recv_stall_pct = 76;
    append_pieces(72);
    drain_text();

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    append_pieces(72);
    drain_text();

    // A number exactly at the cap, then an overlong word that starts with "true"
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    text_q.push_back(etk_pkg::CH_NL);
    for (int i = 0; i < TOKEN_CAP; i++) text_q.push_back(8'("0" + $urandom_range(0, 9)));
    text_q.push_back(etk_pkg::CH_SPACE);
    queue_text("true");
    for (int i = 0; i < TOKEN_CAP - 2; i++) text_q.push_back(word_letter());
    queue_text(" true;");
    text_q.push_back(etk_pkg::CH_NL);
    drain_text();
    in_tvalid <= 1'b0;

    // Hold until every predicted token has come out, then let the queue settle
    while (tokens_waiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d characters over directed text, four idling phases and tokens",
             chars_taken);
    $display("at and past the length cap; checked %0d tokens, %0d of them overlong",
             tokens_seen, overlong_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
